>>> src/irdu_pkg.sv
// ----------------------------------------------------------------------------
// irdu_pkg
// Shared types, constants and the digit alphabet for the radix digit unit.
// ----------------------------------------------------------------------------
package irdu_pkg;

    localparam int DIGIT_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int OUT_TDATA_W = 8;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd62;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic fetch;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        logic bit_last;
        logic quot_zero;
        logic count_last;
        logic rd_zero;
    } t_dp_sts;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < 6'd10) begin
            return CHAR_ZERO + dx;
        end
        if (d < 6'd36) begin
            return CHAR_UPPER_A + (dx - 7'd10);
        end
        return CHAR_LOWER_A + (dx - 7'd36);
    endfunction

endpackage

>>> src/irdu_ctrl.sv
// ----------------------------------------------------------------------------
// irdu_ctrl
// Sequencer: accept, per-digit division, then fetch and emit of stored digits.
// ----------------------------------------------------------------------------
module irdu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output irdu_pkg::t_dp_cmd o_cmd,
    input  irdu_pkg::t_dp_sts i_sts
);
    import irdu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_m_valid = 1'b0;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.bit_last && (i_sts.quot_zero || i_sts.count_last)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                o_m_valid = 1'b1;
                if (i_m_ready) begin
                    if (i_sts.rd_zero) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_out_excl_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_valid |-> !o_s_ready)
        else $error("output valid while input is open");

    a_load_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == ST_DIV))
        else $error("accepted transaction did not start division");

    a_emit_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && i_m_ready && !i_sts.rd_zero) |=> (r_state == ST_FETCH))
        else $error("digit run ended early");

endmodule

>>> src/irdu_dp.sv
// ----------------------------------------------------------------------------
// irdu_dp
// Datapath: radix register, bit-serial divider, digit store and char lookup.
// ----------------------------------------------------------------------------
module irdu_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [irdu_pkg::DIGIT_W-1:0]    i_cfg_radix,
    input  logic [VALUE_BITS-1:0]           i_value,
    input  irdu_pkg::t_dp_cmd               i_cmd,
    output irdu_pkg::t_dp_sts               o_sts,
    output logic [irdu_pkg::CHAR_W-1:0]     o_digit_char
);
    import irdu_pkg::*;

    localparam int IW = $clog2(VALUE_BITS);
    localparam logic [IW-1:0] IDX_LAST = IW'(VALUE_BITS - 1);

    logic [DIGIT_W-1:0]    r_radix;
    logic [DIGIT_W-1:0]    eff_radix;
    logic [VALUE_BITS-1:0] r_quot;
    logic [DIGIT_W-1:0]    r_rem;
    logic [IW-1:0]         r_bit;
    logic [IW-1:0]         r_count;
    logic [IW-1:0]         r_rd_idx;
    logic [DIGIT_W-1:0]    r_rd_data;
    logic [DIGIT_W-1:0]    r_store [VALUE_BITS];

    logic [DIGIT_W:0]      rem_sh;
    logic [DIGIT_W:0]      rem_sub;
    logic                  rem_ge;
    logic [DIGIT_W-1:0]    n_rem;
    logic [VALUE_BITS-1:0] n_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_radix;
        end
    end

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    // one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quot[VALUE_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, eff_radix};
    assign rem_ge  = rem_sh >= {1'b0, eff_radix};
    assign n_rem   = rem_ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
    assign n_quot  = {r_quot[VALUE_BITS-2:0], rem_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_bit   <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_rem   <= '0;
            r_bit   <= '0;
            r_count <= '0;
        end else if (i_cmd.div_step) begin
            if (r_bit == IDX_LAST) begin
                r_rem   <= '0;
                r_bit   <= '0;
                r_count <= r_count + 1'b1;
            end else begin
                r_rem <= n_rem;
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= i_value;
        end else if (i_cmd.div_step) begin
            r_quot <= n_quot;
        end
        if (i_cmd.div_step && (r_bit == IDX_LAST)) begin
            r_store[r_count] <= n_rem;
            r_rd_idx         <= r_count;
        end else if (i_cmd.emit_next) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
        if (i_cmd.fetch) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    assign o_sts.bit_last   = (r_bit == IDX_LAST);
    assign o_sts.quot_zero  = (n_quot == '0);
    assign o_sts.count_last = (r_count == IDX_LAST);
    assign o_sts.rd_zero    = (r_rd_idx == '0);
    assign o_digit_char     = digit_to_ascii(r_rd_data);

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < eff_radix))
        else $error("partial remainder out of range");

endmodule

>>> src/integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts an unsigned value into ASCII digits in a radix from 2 to 62.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one value per transaction, low VALUE_BITS bits of tdata.
//   Master stream: one ASCII digit per transaction, most significant first;
//   tlast marks the least significant digit. Zero gives the single digit '0'.
//   Config channel: 6-bit radix, always ready; write only while idle.
//   Radix below 2 acts as 2, 63 acts as 62.
// Sequence:
//   A value is accepted, then divided once per digit (one quotient bit per
//   cycle in the shared shift-subtract divider), each remainder going to the
//   digit store; then each digit is read from the store and output in turn.
//   The next value is accepted after the final digit's transaction.
// Reset: radix returns to 2, the block goes idle and drops tvalid.
// Stall: a digit on the master side holds until taken; the conversion waits.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [irdu_pkg::DIGIT_W-1:0]           i_cfg_data,   // radix
    // input stream
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]        i_s_axis_tdata,  // value
    // output stream
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [irdu_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,  // digit_char
    output logic                                   o_m_axis_tlast   // last_digit
);
    import irdu_pkg::*;

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [CHAR_W-1:0] digit_char;

    assign o_cfg_ready = 1'b1;

    irdu_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    irdu_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_radix  (i_cfg_data),
        .i_value      (i_s_axis_tdata[VALUE_BITS-1:0]),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_digit_char (digit_char)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, digit_char};
    assign o_m_axis_tlast = sts.rd_zero;

endmodule
